// ===== rtl/core/mtr_pkg.sv =====
// ----------------------------------------------------------------------------
// mtr_pkg
// Shared codes and types of the mesh / torus route computation unit.
// ----------------------------------------------------------------------------
package mtr_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ROUTE_MODE = 3'd0;
  localparam logic [2:0] REG_OWN_X      = 3'd1;
  localparam logic [2:0] REG_OWN_Y      = 3'd2;
  localparam logic [2:0] REG_DIM_X      = 3'd3;
  localparam logic [2:0] REG_DIM_Y      = 3'd4;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 5;

  // routing algorithms
  localparam logic [1:0] MODE_XY    = 2'd0;
  localparam logic [1:0] MODE_TORUS = 2'd1;
  localparam logic [1:0] MODE_DYXY  = 2'd2;

  // output ports
  localparam logic [2:0] PORT_LOCAL = 3'd0;
  localparam logic [2:0] PORT_NORTH = 3'd1;
  localparam logic [2:0] PORT_SOUTH = 3'd2;
  localparam logic [2:0] PORT_WEST  = 3'd3;
  localparam logic [2:0] PORT_EAST  = 3'd4;

  localparam logic [1:0] VC_0 = 2'd0;
  localparam logic [1:0] VC_1 = 2'd1;

  typedef struct packed {
    logic [1:0] route_mode;
    logic [3:0] own_x;
    logic [3:0] own_y;
    logic [4:0] dim_x;
    logic [4:0] dim_y;
  } route_cfg_t;

  // routing decision handed to the candidate emitter
  typedef struct packed {
    logic [2:0] port;
    logic [1:0] vc;
    logic [2:0] tag_port;
    logic [1:0] tag_vc;
    logic       multi;    // one candidate per vc of the port
  } route_dec_t;

endpackage

// ===== rtl/core/mtr_if.sv =====
// ----------------------------------------------------------------------------
// mtr_if
// Request and candidate channels of the route computation unit.
// ----------------------------------------------------------------------------
interface mtr_in_if #(
  parameter int CREDIT_BITS = 6
);
  logic                   valid;
  logic                   ready;
  logic [3:0]             dest_x;
  logic [3:0]             dest_y;
  logic [3:0]             origin_x;
  logic [2:0]             in_port_tag;
  logic [1:0]             in_vc_tag;
  logic [CREDIT_BITS-1:0] credit_east;
  logic [CREDIT_BITS-1:0] credit_west;
  logic [CREDIT_BITS-1:0] credit_north_a;
  logic [CREDIT_BITS-1:0] credit_north_b;
  logic [CREDIT_BITS-1:0] credit_south_a;
  logic [CREDIT_BITS-1:0] credit_south_b;

  modport source (
    output valid, dest_x, dest_y, origin_x, in_port_tag, in_vc_tag,
           credit_east, credit_west, credit_north_a, credit_north_b,
           credit_south_a, credit_south_b,
    input  ready
  );
  modport sink (
    input  valid, dest_x, dest_y, origin_x, in_port_tag, in_vc_tag,
           credit_east, credit_west, credit_north_a, credit_north_b,
           credit_south_a, credit_south_b,
    output ready
  );
endinterface

interface mtr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_port;
  logic [1:0] out_vc;
  logic [2:0] req_port_echo;
  logic [1:0] req_vc_echo;
  logic       last_candidate;

  modport source (
    output valid, out_port, out_vc, req_port_echo, req_vc_echo, last_candidate,
    input  ready
  );
  modport sink (
    input  valid, out_port, out_vc, req_port_echo, req_vc_echo, last_candidate,
    output ready
  );
endinterface

// ===== rtl/core/mtr_route_calc.sv =====
// ----------------------------------------------------------------------------
// mtr_route_calc
// Route decision for one request: plain XY, torus XY or dynamic XY.
// ----------------------------------------------------------------------------
module mtr_route_calc
  import mtr_pkg::*;
#(
  parameter int MAX_DIM     = 16,
  parameter int CREDIT_BITS = 6
) (
  input  route_cfg_t             cfg,
  input  logic [3:0]             dest_x,
  input  logic [3:0]             dest_y,
  input  logic [3:0]             origin_x,
  input  logic [2:0]             tag_port,
  input  logic [1:0]             tag_vc,
  input  logic [CREDIT_BITS-1:0] c_e,
  input  logic [CREDIT_BITS-1:0] c_w,
  input  logic [CREDIT_BITS-1:0] c_n0,
  input  logic [CREDIT_BITS-1:0] c_n1,
  input  logic [CREDIT_BITS-1:0] c_s0,
  input  logic [CREDIT_BITS-1:0] c_s1,
  output route_dec_t             dec
);

  // ring size cap, limited to what the 5-bit register can hold
  localparam int DimCap = (MAX_DIM > 31) ? 31 : MAX_DIM;

  logic [4:0] ring_x, ring_y;
  logic [3:0] ax, ay;
  logic       x_neg, y_neg, xdir, ydir;
  logic [2:0] port;
  logic [1:0] vc;

  always_comb begin
    ring_x = (cfg.dim_x > 5'(DimCap)) ? 5'(DimCap) : cfg.dim_x;
    ring_y = (cfg.dim_y > 5'(DimCap)) ? 5'(DimCap) : cfg.dim_y;
    x_neg  = dest_x < cfg.own_x;
    y_neg  = dest_y < cfg.own_y;
    ax     = x_neg ? (cfg.own_x - dest_x) : (dest_x - cfg.own_x);
    ay     = y_neg ? (cfg.own_y - dest_y) : (dest_y - cfg.own_y);
    xdir   = {ax, 1'b0} <= ring_x;
    ydir   = {ay, 1'b0} <= ring_y;
    port   = PORT_LOCAL;
    vc     = VC_0;

    case (cfg.route_mode)
      MODE_TORUS: begin
        if (dest_x != cfg.own_x) begin
          port = (x_neg == xdir) ? PORT_WEST : PORT_EAST;
        end else if (dest_y != cfg.own_y) begin
          port = (y_neg == ydir) ? PORT_NORTH : PORT_SOUTH;
        end
      end
      MODE_DYXY: begin
        if (cfg.own_y == dest_y) begin
          if (cfg.own_x == dest_x) port = PORT_LOCAL;
          else port = (cfg.own_x < dest_x) ? PORT_EAST : PORT_WEST;
        end else if (cfg.own_x == dest_x) begin
          if (cfg.own_y > dest_y) begin
            port = PORT_NORTH;
            vc   = (dest_x > origin_x) ? VC_0 : VC_1;
          end else begin
            port = PORT_SOUTH;
            vc   = (dest_x < origin_x) ? VC_1 : VC_0;
          end
        end else if (cfg.own_y > dest_y && cfg.own_x < dest_x) begin
          if (c_e >= c_n0) port = PORT_EAST;
          else port = PORT_NORTH;
        end else if (cfg.own_y > dest_y) begin
          if (c_w >= c_n1) begin
            port = PORT_WEST;
          end else begin
            port = PORT_NORTH;
            vc   = VC_1;
          end
        end else if (cfg.own_x < dest_x) begin
          if (c_s0 >= c_e) port = PORT_SOUTH;
          else port = PORT_EAST;
        end else begin
          if (c_s1 >= c_w) begin
            port = PORT_SOUTH;
            vc   = VC_1;
          end else begin
            port = PORT_WEST;
          end
        end
      end
      default: begin
        // plain XY, also for the undefined mode
        if (cfg.own_x > dest_x)      port = PORT_WEST;
        else if (cfg.own_x < dest_x) port = PORT_EAST;
        else if (cfg.own_y > dest_y) port = PORT_NORTH;
        else if (cfg.own_y < dest_y) port = PORT_SOUTH;
        else                         port = PORT_LOCAL;
      end
    endcase

    dec.port     = port;
    dec.vc       = vc;
    dec.tag_port = tag_port;
    dec.tag_vc   = tag_vc;
    dec.multi    = (cfg.route_mode != MODE_TORUS) && (cfg.route_mode != MODE_DYXY);
  end

endmodule

// ===== rtl/core/mtr_cand_emit.sv =====
// ----------------------------------------------------------------------------
// mtr_cand_emit
// Result register; steps through the vcs of a plain XY decision.
// ----------------------------------------------------------------------------
module mtr_cand_emit
  import mtr_pkg::*;
#(
  parameter int VCS_PER_PORT = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          dec_valid,
  input  route_dec_t    dec,
  output logic          dec_take,
  mtr_out_if.source     out_ch
);

  localparam int         NumCand = (VCS_PER_PORT > 4) ? 4 : VCS_PER_PORT;
  localparam logic [1:0] LastVc  = 2'(NumCand - 1);

  logic       valid_r;
  route_dec_t cur_r;
  logic       last;

  assign last     = !cur_r.multi || (cur_r.vc == LastVc);
  assign dec_take = !valid_r || (out_ch.ready && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (dec_take) begin
      valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_take) begin
      cur_r <= dec;
    end else if (out_ch.ready) begin
      cur_r.vc <= cur_r.vc + 2'd1;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.out_port       = cur_r.port;
  assign out_ch.out_vc         = cur_r.vc;
  assign out_ch.req_port_echo  = cur_r.tag_port;
  assign out_ch.req_vc_echo    = cur_r.tag_vc;
  assign out_ch.last_candidate = last;

endmodule

// ===== rtl/core/mesh_torus_route_compute.sv =====
// ----------------------------------------------------------------------------
// mesh_torus_route_compute
// Route computation unit of a 2D mesh / torus router.
//
//   channel  dir  handshake       contents
//   in_ch    in   valid/ready     destination, source x, tags, credits
//   out_ch   out  valid/ready     port, vc, echoed tags, last flag
//   cfg_*    in   write enable    route_mode, own_x, own_y, dim_x, dim_y
//
// A request goes through an input register and the route logic into the
// result register. Torus and dynamic XY give one word per request, plain XY
// one word per vc (up to four). The result port sets the rate: one request
// per cycle while it is ready, the next XY request only after the last vc word.
// Reset is synchronous, clears the valid flags and loads the router
// settings with their defaults.
// A stalled result port holds the input register, which still takes a word
// if it is empty while the result register is busy with a request that has
// words left.
// ----------------------------------------------------------------------------
module mesh_torus_route_compute
  import mtr_pkg::*;
#(
  parameter int VCS_PER_PORT = 4,
  parameter int MAX_DIM      = 16,
  parameter int CREDIT_BITS  = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  mtr_in_if.sink                 in_ch,
  mtr_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_idx,
  input  logic [CfgDataBits-1:0] cfg_wdata
);

  route_cfg_t cfg_r;

  logic                   s1_valid_r;
  logic [3:0]             dest_x_r, dest_y_r, origin_x_r;
  logic [2:0]             tag_port_r;
  logic [1:0]             tag_vc_r;
  logic [CREDIT_BITS-1:0] c_e_r, c_w_r, c_n0_r, c_n1_r, c_s0_r, c_s1_r;

  route_dec_t dec;
  logic       dec_take;
  logic       s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.route_mode <= MODE_XY;
      cfg_r.own_x      <= 4'd0;
      cfg_r.own_y      <= 4'd0;
      cfg_r.dim_x      <= 5'd4;
      cfg_r.dim_y      <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROUTE_MODE: cfg_r.route_mode <= cfg_wdata[1:0];
        REG_OWN_X:      cfg_r.own_x      <= cfg_wdata[3:0];
        REG_OWN_Y:      cfg_r.own_y      <= cfg_wdata[3:0];
        REG_DIM_X:      cfg_r.dim_x      <= cfg_wdata[4:0];
        REG_DIM_Y:      cfg_r.dim_y      <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !s1_valid_r || dec_take;
  assign s1_load     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      dest_x_r   <= in_ch.dest_x;
      dest_y_r   <= in_ch.dest_y;
      origin_x_r <= in_ch.origin_x;
      tag_port_r <= in_ch.in_port_tag;
      tag_vc_r   <= in_ch.in_vc_tag;
      c_e_r      <= in_ch.credit_east;
      c_w_r      <= in_ch.credit_west;
      c_n0_r     <= in_ch.credit_north_a;
      c_n1_r     <= in_ch.credit_north_b;
      c_s0_r     <= in_ch.credit_south_a;
      c_s1_r     <= in_ch.credit_south_b;
    end
  end

  mtr_route_calc #(
    .MAX_DIM     (MAX_DIM),
    .CREDIT_BITS (CREDIT_BITS)
  ) u_calc (
    .cfg      (cfg_r),
    .dest_x   (dest_x_r),
    .dest_y   (dest_y_r),
    .origin_x (origin_x_r),
    .tag_port (tag_port_r),
    .tag_vc   (tag_vc_r),
    .c_e      (c_e_r),
    .c_w      (c_w_r),
    .c_n0     (c_n0_r),
    .c_n1     (c_n1_r),
    .c_s0     (c_s0_r),
    .c_s1     (c_s1_r),
    .dec      (dec)
  );

  mtr_cand_emit #(
    .VCS_PER_PORT (VCS_PER_PORT)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (s1_valid_r),
    .dec       (dec),
    .dec_take  (dec_take),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mesh / torus route computation unit. A local
// route predictor follows every accepted request word and queues the
// candidate words it must cause; each candidate word that leaves the block
// is compared field by field with the oldest queued one. Directed requests
// cover plain XY, torus XY around the ring boundaries, every dynamic XY
// case with credit ties, and the undefined mode. Random phases follow under
// several router settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import mtr_pkg::*;

  localparam int VCS   = 4;
  localparam int MDIM  = 16;
  localparam int CB    = 6;
  localparam int LIMIT = 300000;

  // route_mode 3 has no algorithm of its own and falls back to plain XY
  localparam logic [1:0] MODE_UNDEF = 2'd3;

  typedef struct packed {
    logic [3:0]    dest_x;
    logic [3:0]    dest_y;
    logic [3:0]    origin_x;
    logic [2:0]    port_tag;
    logic [1:0]    vc_tag;
    logic [CB-1:0] c_east;
    logic [CB-1:0] c_west;
    logic [CB-1:0] c_north_a;
    logic [CB-1:0] c_north_b;
    logic [CB-1:0] c_south_a;
    logic [CB-1:0] c_south_b;
  } route_req_t;

  typedef struct packed {
    logic [2:0] port;
    logic [1:0] vc;
    logic [2:0] port_echo;
    logic [1:0] vc_echo;
    logic       last;
  } cand_t;

  logic clk;
  logic rst_n;
  logic                   cfg_we;
  logic [CfgIdxBits-1:0]  cfg_idx;
  logic [CfgDataBits-1:0] cfg_wdata;

  mtr_in_if #(.CREDIT_BITS(CB)) in_ch ();
  mtr_out_if                    out_ch ();

  mesh_torus_route_compute #(
    .VCS_PER_PORT (VCS),
    .MAX_DIM      (MDIM),
    .CREDIT_BITS  (CB)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // router settings as the block should hold them
  logic [1:0] sh_mode;
  logic [3:0] sh_own_x;
  logic [3:0] sh_own_y;
  logic [4:0] sh_dim_x;
  logic [4:0] sh_dim_y;

  cand_t      cand_q[$];
  cand_t      head_cand;
  route_req_t seen_req;
  int         n_fail;
  int         cycle_cnt;
  bit         calm;
  int         rdy_hold;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_cand(logic [2:0] port, logic [1:0] vc, route_req_t r,
                                    logic last);
    cand_t c;
    c.port      = port;
    c.vc        = vc;
    c.port_echo = r.port_tag;
    c.vc_echo   = r.vc_tag;
    c.last      = last;
    cand_q.push_back(c);
  endfunction

  function automatic void predict_candidates(route_req_t r);
    int ox, oy, dx, dy, sx, xo, yo, ax, ay, rx, ry, n;
    logic [2:0] port;
    logic [1:0] vc;
    bit xdir, ydir;
    ox = int'(sh_own_x);
    oy = int'(sh_own_y);
    dx = int'(r.dest_x);
    dy = int'(r.dest_y);
    sx = int'(r.origin_x);
    xo = dx - ox;
    yo = dy - oy;
    port = PORT_LOCAL;
    vc = VC_0;
    if (sh_mode == MODE_TORUS) begin
      ax = xo < 0 ? -xo : xo;
      ay = yo < 0 ? -yo : yo;
      rx = sh_dim_x > MDIM ? MDIM : int'(sh_dim_x);
      ry = sh_dim_y > MDIM ? MDIM : int'(sh_dim_y);
      xdir = (ax * 2) <= rx;
      ydir = (ay * 2) <= ry;
      // short way round unless the offset is more than half the ring
      if (xo != 0) port = ((xo < 0) == xdir) ? PORT_WEST : PORT_EAST;
      else if (yo != 0) port = ((yo < 0) == ydir) ? PORT_NORTH : PORT_SOUTH;
      push_cand(port, VC_0, r, 1'b1);
    end else if (sh_mode == MODE_DYXY) begin
      if (oy == dy) begin
        port = ox == dx ? PORT_LOCAL : (ox < dx ? PORT_EAST : PORT_WEST);
      end else if (ox == dx) begin
        if (oy > dy) begin
          port = PORT_NORTH;
          vc = dx > sx ? VC_0 : VC_1;
        end else begin
          port = PORT_SOUTH;
          vc = dx < sx ? VC_1 : VC_0;
        end
      end else if (oy > dy && ox < dx) begin
        if (r.c_east >= r.c_north_a) port = PORT_EAST;
        else begin
          port = PORT_NORTH;
          vc = VC_0;
        end
      end else if (oy > dy) begin
        if (r.c_west >= r.c_north_b) port = PORT_WEST;
        else begin
          port = PORT_NORTH;
          vc = VC_1;
        end
      end else if (ox < dx) begin
        if (r.c_south_a >= r.c_east) begin
          port = PORT_SOUTH;
          vc = VC_0;
        end else port = PORT_EAST;
      end else begin
        if (r.c_south_b >= r.c_west) begin
          port = PORT_SOUTH;
          vc = VC_1;
        end else port = PORT_WEST;
      end
      push_cand(port, vc, r, 1'b1);
    end else begin
      n = VCS > 4 ? 4 : VCS;
      if (ox > dx) port = PORT_WEST;
      else if (ox < dx) port = PORT_EAST;
      else if (oy > dy) port = PORT_NORTH;
      else if (oy < dy) port = PORT_SOUTH;
      for (int i = 0; i < n; i++) push_cand(port, 2'(i), r, i == n - 1);
    end
  endfunction

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      n_fail++;
    end
  endfunction

  // result checking, request tracking and the settings copy
  always @(posedge clk) begin
    if (!rst_n) begin
      sh_mode  <= MODE_XY;
      sh_own_x <= 4'd0;
      sh_own_y <= 4'd0;
      sh_dim_x <= 5'd4;
      sh_dim_y <= 5'd4;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (cand_q.size() == 0) begin
          $error("candidate word with none expected: port %0d vc %0d",
                 out_ch.out_port, out_ch.out_vc);
          n_fail++;
        end else begin
          head_cand = cand_q.pop_front();
          check_field("out_port", head_cand.port, out_ch.out_port);
          check_field("out_vc", head_cand.vc, out_ch.out_vc);
          check_field("req_port_echo", head_cand.port_echo, out_ch.req_port_echo);
          check_field("req_vc_echo", head_cand.vc_echo, out_ch.req_vc_echo);
          check_field("last_candidate", head_cand.last, out_ch.last_candidate);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_req.dest_x    = in_ch.dest_x;
        seen_req.dest_y    = in_ch.dest_y;
        seen_req.origin_x  = in_ch.origin_x;
        seen_req.port_tag  = in_ch.in_port_tag;
        seen_req.vc_tag    = in_ch.in_vc_tag;
        seen_req.c_east    = in_ch.credit_east;
        seen_req.c_west    = in_ch.credit_west;
        seen_req.c_north_a = in_ch.credit_north_a;
        seen_req.c_north_b = in_ch.credit_north_b;
        seen_req.c_south_a = in_ch.credit_south_a;
        seen_req.c_south_b = in_ch.credit_south_b;
        predict_candidates(seen_req);
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_ROUTE_MODE: sh_mode  <= cfg_wdata[1:0];
          REG_OWN_X:      sh_own_x <= cfg_wdata[3:0];
          REG_OWN_Y:      sh_own_y <= cfg_wdata[3:0];
          REG_DIM_X:      sh_dim_x <= cfg_wdata;
          REG_DIM_Y:      sh_dim_y <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // result port back-pressure
  always @(posedge clk) begin
    if (rdy_hold != 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= !out_ch.ready;
      rdy_hold <= out_ch.ready ? pick_gap() : $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("[mesh_torus_route_compute] ERROR");
      $finish;
    end
  end

  function automatic route_req_t mk_req(int dx, int dy, int sx, int pt, int vt,
                                        int ce, int cw, int cn0, int cn1,
                                        int cs0, int cs1);
    route_req_t r;
    r.dest_x    = 4'(dx);
    r.dest_y    = 4'(dy);
    r.origin_x  = 4'(sx);
    r.port_tag  = 3'(pt);
    r.vc_tag    = 2'(vt);
    r.c_east    = CB'(ce);
    r.c_west    = CB'(cw);
    r.c_north_a = CB'(cn0);
    r.c_north_b = CB'(cn1);
    r.c_south_a = CB'(cs0);
    r.c_south_b = CB'(cs1);
    return r;
  endfunction

  // valid stays high into a back-to-back word and drops only across a gap
  task automatic drive_request(route_req_t r);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.dest_x         <= r.dest_x;
    in_ch.dest_y         <= r.dest_y;
    in_ch.origin_x       <= r.origin_x;
    in_ch.in_port_tag    <= r.port_tag;
    in_ch.in_vc_tag      <= r.vc_tag;
    in_ch.credit_east    <= r.c_east;
    in_ch.credit_west    <= r.c_west;
    in_ch.credit_north_a <= r.c_north_a;
    in_ch.credit_north_b <= r.c_north_b;
    in_ch.credit_south_a <= r.c_south_a;
    in_ch.credit_south_b <= r.c_south_b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic release_in();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    while (cand_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_route_cfg(logic [CfgDataBits-1:0] mode_w, int ox, int oy,
                               int dxv, int dyv);
    wait_results();
    repeat (4) @(posedge clk);
    write_reg(REG_ROUTE_MODE, mode_w);
    write_reg(REG_OWN_X, 5'(ox));
    write_reg(REG_OWN_Y, 5'(oy));
    write_reg(REG_DIM_X, 5'(dxv));
    write_reg(REG_DIM_Y, 5'(dyv));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r < 4) return 15;
    return $urandom_range(0, 15);
  endfunction

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 0;
      1: return 1;
      2: return 16;
      3: return 31;
      default: return $urandom_range(1, 31);
    endcase
  endfunction

  function automatic route_req_t rand_req();
    route_req_t r;
    int sel, rx, ry, c;
    r.dest_x    = 4'($urandom_range(0, 15));
    r.dest_y    = 4'($urandom_range(0, 15));
    r.origin_x  = 4'($urandom_range(0, 15));
    r.port_tag  = 3'($urandom_range(0, 7));
    r.vc_tag    = 2'($urandom_range(0, 3));
    r.c_east    = CB'($urandom_range(0, 63));
    r.c_west    = CB'($urandom_range(0, 63));
    r.c_north_a = CB'($urandom_range(0, 63));
    r.c_north_b = CB'($urandom_range(0, 63));
    r.c_south_a = CB'($urandom_range(0, 63));
    r.c_south_b = CB'($urandom_range(0, 63));
    rx = sh_dim_x > MDIM ? MDIM : int'(sh_dim_x);
    ry = sh_dim_y > MDIM ? MDIM : int'(sh_dim_y);
    sel = $urandom_range(0, 99);
    // lean toward same row / column and the half-ring boundary
    if (sel < 20) r.dest_x = sh_own_x;
    else if (sel < 30) r.dest_x = sh_own_x + 4'(rx / 2);
    else if (sel < 40) r.dest_x = sh_own_x - 4'(rx / 2);
    sel = $urandom_range(0, 99);
    if (sel < 20) r.dest_y = sh_own_y;
    else if (sel < 30) r.dest_y = sh_own_y + 4'(ry / 2);
    else if (sel < 40) r.dest_y = sh_own_y - 4'(ry / 2);
    if ($urandom_range(0, 4) == 0) begin
      c = $urandom_range(0, 63);
      r.c_east    = CB'(c);
      r.c_west    = CB'(c);
      r.c_north_a = CB'(c);
      r.c_north_b = CB'(c);
      r.c_south_a = CB'(c);
      r.c_south_b = CB'(c);
    end
    return r;
  endfunction

  task automatic test_reset_defaults();
    drive_request(mk_req(0, 0, 15, 7, 3, 63, 0, 63, 0, 63, 0));
    drive_request(mk_req(15, 15, 0, 0, 0, 0, 63, 0, 63, 0, 63));
    release_in();
  endtask

  task automatic test_plain_xy();
    set_route_cfg({3'd0, MODE_XY}, 7, 7, 4, 4);
    drive_request(mk_req(3, 15, 0, 4, 1, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(12, 0, 15, 1, 2, 63, 63, 63, 63, 63, 63));
    drive_request(mk_req(7, 2, 7, 2, 3, 5, 9, 1, 7, 3, 2));
    drive_request(mk_req(7, 12, 3, 3, 0, 40, 1, 22, 8, 0, 63));
    release_in();
  endtask

  task automatic test_torus_wrap();
    set_route_cfg({3'd0, MODE_TORUS}, 5, 9, 16, 31);
    drive_request(mk_req(13, 9, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(14, 9, 15, 1, 2, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(5, 1, 3, 2, 3, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(5, 0, 8, 4, 0, 0, 0, 0, 0, 0, 0));
    release_in();
    // zero and unit ring sizes
    set_route_cfg({3'd0, MODE_TORUS}, 5, 9, 0, 1);
    drive_request(mk_req(6, 9, 2, 3, 1, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(5, 10, 2, 3, 1, 0, 0, 0, 0, 0, 0));
    release_in();
  endtask

  task automatic test_dynamic_xy();
    set_route_cfg({3'd0, MODE_DYXY}, 8, 8, 4, 4);
    drive_request(mk_req(8, 8, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(12, 8, 1, 1, 1, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(3, 8, 1, 2, 2, 0, 0, 0, 0, 0, 0));
    // same column: the source side picks the vc
    drive_request(mk_req(8, 2, 3, 3, 3, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(8, 2, 8, 4, 0, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(8, 14, 15, 0, 1, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(8, 14, 0, 1, 2, 0, 0, 0, 0, 0, 0));
    // diagonals: equal credits keep the x direction going north, the y direction going south
    drive_request(mk_req(12, 2, 0, 2, 3, 40, 0, 40, 0, 0, 0));
    drive_request(mk_req(12, 2, 0, 3, 0, 10, 0, 11, 0, 0, 0));
    drive_request(mk_req(2, 2, 0, 4, 1, 0, 63, 0, 63, 0, 0));
    drive_request(mk_req(2, 2, 0, 0, 2, 0, 62, 0, 63, 0, 0));
    drive_request(mk_req(12, 14, 0, 1, 3, 33, 0, 0, 0, 33, 0));
    drive_request(mk_req(12, 14, 0, 2, 0, 34, 0, 0, 0, 33, 0));
    drive_request(mk_req(2, 14, 0, 3, 1, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(2, 14, 0, 4, 2, 0, 1, 0, 0, 0, 0));
    release_in();
  endtask

  task automatic test_undefined_mode();
    set_route_cfg({3'd0, MODE_UNDEF}, 15, 0, 1, 0);
    drive_request(mk_req(15, 15, 9, 6, 3, 12, 34, 56, 7, 8, 9));
    release_in();
  endtask

  task automatic test_random_phases();
    logic [1:0] modes [6];
    int dxv, dyv;
    modes = '{MODE_TORUS, MODE_DYXY, MODE_XY, MODE_TORUS, MODE_DYXY, MODE_UNDEF};
    for (int ph = 0; ph < 6; ph++) begin
      dxv = pick_dim();
      dyv = pick_dim();
      if (ph == 0) begin
        dxv = 16;
        dyv = 16;
      end else if (ph == 3) begin
        dxv = 0;
        dyv = 31;
      end
      set_route_cfg({3'($urandom_range(0, 7)), modes[ph]}, pick_coord(), pick_coord(),
                    dxv, dyv);
      calm = (ph == 4);
      for (int i = 0; i < 12; i++) begin
        if (ph == 2 && i == 8) begin
          // hold off until the block has drained
          release_in();
          wait_results();
        end
        drive_request(rand_req());
      end
      release_in();
      calm = 1'b0;
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.dest_x         = '0;
    in_ch.dest_y         = '0;
    in_ch.origin_x       = '0;
    in_ch.in_port_tag    = '0;
    in_ch.in_vc_tag      = '0;
    in_ch.credit_east    = '0;
    in_ch.credit_west    = '0;
    in_ch.credit_north_a = '0;
    in_ch.credit_north_b = '0;
    in_ch.credit_south_a = '0;
    in_ch.credit_south_b = '0;
    out_ch.ready         = 1'b0;
    n_fail               = 0;
    cycle_cnt            = 0;
    calm                 = 1'b0;
    rdy_hold             = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_plain_xy();
    test_torus_wrap();
    test_dynamic_xy();
    test_undefined_mode();
    test_random_phases();

    wait_results();
    repeat (10) @(posedge clk);
    if (n_fail == 0) begin
      $display("[mesh_torus_route_compute] OK");
    end else begin
      $display("[mesh_torus_route_compute] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mtr_pkg.sv
rtl/core/mtr_if.sv
rtl/core/mtr_route_calc.sv
rtl/core/mtr_cand_emit.sv
rtl/core/mesh_torus_route_compute.sv
tb/sv/testbench.sv
